[src/sfd_pkg.sv]
// Package with the shared constants and types of the sensor frame deframer.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 16;
    localparam int STAMP_W = 32;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W = 3;
    localparam int FIDX_W  = 2;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [FIDX_W-1:0]    fidx_t;

    localparam kind_t KIND_HEADER   = 2'd0;
    localparam kind_t KIND_PAYLOAD  = 2'd1;
    localparam kind_t KIND_BAD_TYPE = 2'd2;
    localparam kind_t KIND_OVERSIZE = 2'd3;

    localparam cfg_idx_t REG_START_CODE      = 2'd0;
    localparam cfg_idx_t REG_RAW_TYPE        = 2'd1;
    localparam cfg_idx_t REG_COMPRESSED_TYPE = 2'd2;
    localparam cfg_idx_t REG_SIZE_LIMIT      = 2'd3;

    localparam byte_t RST_START_CODE      = 8'd170;
    localparam byte_t RST_RAW_TYPE        = 8'd1;
    localparam byte_t RST_COMPRESSED_TYPE = 8'd2;
    localparam size_t RST_SIZE_LIMIT      = 16'd2048;

    localparam phase_t PH_HUNT    = 3'd0;
    localparam phase_t PH_TYPE    = 3'd1;
    localparam phase_t PH_BEACON  = 3'd2;
    localparam phase_t PH_SENSOR  = 3'd3;
    localparam phase_t PH_SIZE    = 3'd4;
    localparam phase_t PH_STAMP   = 3'd5;
    localparam phase_t PH_PAYLOAD = 3'd6;

    localparam fidx_t FIDX_LAST_STAMP = 2'd3;

endpackage

`default_nettype wire

[src/sensor_frame_deframer.sv]
// Top level of the sensor frame deframer: byte parser with input and result registers.
//
// The block takes one received byte per input transaction on rx_byte (in_valid/in_stall)
// and hunts for the start byte, then reads type, beacon id, sensor id, a little-endian
// 16-bit size and a little-endian 32-bit timestamp. It reports a header, each payload
// byte (frame_end on the last one, or on the header of a frame without payload), a bad
// type or an oversize frame as one result transaction on out_valid/out_stall. Bytes that
// complete no result give nothing. A byte is held in an input register, and its result
// is then written to the result register, from which it can be taken. One byte is
// accepted every cycle while the receiver does not stall; the parser state is updated
// in a single pass from the input register, so the rate is set by that one update.
// While the receiver stalls, the result stays in the result register, one more byte
// waits in the input register, and in_stall rises until the result is taken.
// Reset clears all transactions in flight, returns the parser to the hunt and loads
// the register defaults. The configuration registers are written through cfg_write,
// cfg_index and cfg_data and should only be changed while the block is idle.
`default_nettype none

module sensor_frame_deframer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire sfd_pkg::cfg_idx_t cfg_index,
    input  wire sfd_pkg::cfg_data_t cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sfd_pkg::byte_t   rx_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output sfd_pkg::kind_t        result_kind,
    output sfd_pkg::byte_t        frame_type,
    output sfd_pkg::byte_t        beacon,
    output sfd_pkg::byte_t        sensor,
    output sfd_pkg::size_t        payload_size,
    output sfd_pkg::stamp_t       stamp,
    output sfd_pkg::byte_t        payload_byte,
    output logic                  frame_end
);
    import sfd_pkg::*;

    byte_t  start_code_reg;
    byte_t  raw_type_reg;
    byte_t  comp_type_reg;
    size_t  size_limit_reg;

    logic   byte_valid_reg;
    byte_t  byte_reg;

    phase_t phase_reg, phase_next;
    fidx_t  fidx_reg, fidx_next;
    byte_t  type_reg, type_next;
    byte_t  beacon_reg, beacon_next;
    byte_t  sensor_reg, sensor_next;
    size_t  size_reg, size_next;
    stamp_t stamp_reg, stamp_next;
    size_t  remain_reg, remain_next;

    logic   out_valid_reg;
    kind_t  kind_reg, kind_next;
    byte_t  otype_reg, otype_next;
    byte_t  obeacon_reg, obeacon_next;
    byte_t  osensor_reg, osensor_next;
    size_t  osize_reg, osize_next;
    stamp_t ostamp_reg, ostamp_next;
    byte_t  obyte_reg, obyte_next;
    logic   oend_reg, oend_next;
    logic   emit;

    logic   advance;
    logic   step;
    size_t  full_size;
    stamp_t full_stamp;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = byte_valid_reg && advance;
    assign in_stall = byte_valid_reg && !advance;

    assign full_size = {byte_reg, size_reg[BYTE_W-1:0]};

    always_comb
    begin
        case (fidx_reg)
            2'd0:    full_stamp = {24'd0, byte_reg};
            2'd1:    full_stamp = stamp_reg | {16'd0, byte_reg, 8'd0};
            2'd2:    full_stamp = stamp_reg | {8'd0, byte_reg, 16'd0};
            default: full_stamp = stamp_reg | {byte_reg, 24'd0};
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        fidx_next    = fidx_reg;
        type_next    = type_reg;
        beacon_next  = beacon_reg;
        sensor_next  = sensor_reg;
        size_next    = size_reg;
        stamp_next   = stamp_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        kind_next    = KIND_HEADER;
        otype_next   = type_reg;
        obeacon_next = beacon_reg;
        osensor_next = sensor_reg;
        osize_next   = size_reg;
        ostamp_next  = stamp_reg;
        obyte_next   = '0;
        oend_next    = 1'b0;
        case (phase_reg)
            PH_TYPE:
            begin
                if (byte_reg != raw_type_reg && byte_reg != comp_type_reg)
                begin
                    phase_next   = PH_HUNT;
                    emit         = 1'b1;
                    kind_next    = KIND_BAD_TYPE;
                    otype_next   = byte_reg;
                    obeacon_next = '0;
                    osensor_next = '0;
                    osize_next   = '0;
                    ostamp_next  = '0;
                end
                else
                begin
                    type_next  = byte_reg;
                    phase_next = PH_BEACON;
                end
            end
            PH_BEACON:
            begin
                beacon_next = byte_reg;
                phase_next  = PH_SENSOR;
            end
            PH_SENSOR:
            begin
                sensor_next = byte_reg;
                phase_next  = PH_SIZE;
                fidx_next   = '0;
            end
            PH_SIZE:
            begin
                if (fidx_reg == 2'd0)
                begin
                    size_next = {8'd0, byte_reg};
                    fidx_next = 2'd1;
                end
                else
                begin
                    size_next = full_size;
                    fidx_next = '0;
                    if (full_size > size_limit_reg)
                    begin
                        phase_next  = PH_HUNT;
                        emit        = 1'b1;
                        kind_next   = KIND_OVERSIZE;
                        osize_next  = full_size;
                        ostamp_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_STAMP;
                    end
                end
            end
            PH_STAMP:
            begin
                stamp_next = full_stamp;
                if (fidx_reg != FIDX_LAST_STAMP)
                begin
                    fidx_next = fidx_reg + 2'd1;
                end
                else
                begin
                    fidx_next   = '0;
                    emit        = 1'b1;
                    kind_next   = KIND_HEADER;
                    ostamp_next = full_stamp;
                    remain_next = size_reg;
                    if (size_reg == '0)
                    begin
                        phase_next = PH_HUNT;
                        oend_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit       = 1'b1;
                kind_next  = KIND_PAYLOAD;
                obyte_next = byte_reg;
                if (remain_reg <= 16'd1)
                begin
                    oend_next   = 1'b1;
                    remain_next = '0;
                    phase_next  = PH_HUNT;
                end
                else
                begin
                    remain_next = remain_reg - 16'd1;
                end
            end
            default:
            begin
                if (byte_reg == start_code_reg)
                begin
                    phase_next = PH_TYPE;
                    fidx_next  = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= RST_START_CODE;
            raw_type_reg   <= RST_RAW_TYPE;
            comp_type_reg  <= RST_COMPRESSED_TYPE;
            size_limit_reg <= RST_SIZE_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_CODE:      start_code_reg <= cfg_data[BYTE_W-1:0];
                REG_RAW_TYPE:        raw_type_reg   <= cfg_data[BYTE_W-1:0];
                REG_COMPRESSED_TYPE: comp_type_reg  <= cfg_data[BYTE_W-1:0];
                REG_SIZE_LIMIT:      size_limit_reg <= cfg_data[SIZE_W-1:0];
                default:             size_limit_reg <= size_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            fidx_reg   <= '0;
            type_reg   <= '0;
            beacon_reg <= '0;
            sensor_reg <= '0;
            size_reg   <= '0;
            stamp_reg  <= '0;
            remain_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fidx_reg   <= fidx_next;
            type_reg   <= type_next;
            beacon_reg <= beacon_next;
            sensor_reg <= sensor_next;
            size_reg   <= size_next;
            stamp_reg  <= stamp_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            kind_reg    <= kind_next;
            otype_reg   <= otype_next;
            obeacon_reg <= obeacon_next;
            osensor_reg <= osensor_next;
            osize_reg   <= osize_next;
            ostamp_reg  <= ostamp_next;
            obyte_reg   <= obyte_next;
            oend_reg    <= oend_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign frame_type   = otype_reg;
    assign beacon       = obeacon_reg;
    assign sensor       = osensor_reg;
    assign payload_size = osize_reg;
    assign stamp        = ostamp_reg;
    assign payload_byte = obyte_reg;
    assign frame_end    = oend_reg;

endmodule

`default_nettype wire

[tb/sv/sfd_tb_pkg.sv]
// Expected-report tracking for the sensor frame deframer testbench.
package sfd_tb_pkg;

    import sfd_pkg::*;

    typedef struct packed {
        kind_t  kind;
        byte_t  ftype;
        byte_t  beacon_val;
        byte_t  sensor_val;
        size_t  size;
        stamp_t ts;
        byte_t  pbyte;
        logic   last;
    } frame_report_t;

    class frame_report_tracker;
        byte_t  start_code;
        byte_t  raw_code;
        byte_t  comp_code;
        size_t  size_limit;

        phase_t phase;
        fidx_t  fidx;
        byte_t  cur_type;
        byte_t  cur_beacon;
        byte_t  cur_sensor;
        size_t  cur_size;
        stamp_t cur_stamp;
        size_t  remaining;

        frame_report_t reports_due[$];
        int unsigned   faults;
        int unsigned   kind_count[4];

        function new();
            start_code = RST_START_CODE;
            raw_code   = RST_RAW_TYPE;
            comp_code  = RST_COMPRESSED_TYPE;
            size_limit = RST_SIZE_LIMIT;
            phase      = PH_HUNT;
            fidx       = '0;
            cur_type   = '0;
            cur_beacon = '0;
            cur_sensor = '0;
            cur_size   = '0;
            cur_stamp  = '0;
            remaining  = '0;
            faults     = 0;
            kind_count = '{default: 0};
        endfunction

        function void write_register(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                REG_START_CODE:      start_code = data[BYTE_W-1:0];
                REG_RAW_TYPE:        raw_code   = data[BYTE_W-1:0];
                REG_COMPRESSED_TYPE: comp_code  = data[BYTE_W-1:0];
                REG_SIZE_LIMIT:      size_limit = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function frame_report_t make_report(kind_t k, byte_t t, bit with_ids, bit with_size,
                                            bit with_stamp, byte_t pb, logic last);
            frame_report_t r;
            r.kind       = k;
            r.ftype      = t;
            r.beacon_val = with_ids ? cur_beacon : '0;
            r.sensor_val = with_ids ? cur_sensor : '0;
            r.size       = with_size ? cur_size : '0;
            r.ts         = with_stamp ? cur_stamp : '0;
            r.pbyte      = pb;
            r.last       = last;
            return r;
        endfunction

        // Advances the parser by one accepted byte and queues the report it causes, if any.
        function void accept_byte(byte_t b);
            logic last;
            case (phase)
                PH_TYPE:
                begin
                    if (b != raw_code && b != comp_code)
                    begin
                        phase = PH_HUNT;
                        reports_due.push_back(make_report(KIND_BAD_TYPE, b, 0, 0, 0, '0, 1'b0));
                    end
                    else
                    begin
                        cur_type = b;
                        phase    = PH_BEACON;
                    end
                end
                PH_BEACON:
                begin
                    cur_beacon = b;
                    phase      = PH_SENSOR;
                end
                PH_SENSOR:
                begin
                    cur_sensor = b;
                    phase      = PH_SIZE;
                    fidx       = '0;
                end
                PH_SIZE:
                begin
                    if (fidx == '0)
                    begin
                        cur_size = {8'h00, b};
                        fidx     = 2'd1;
                    end
                    else
                    begin
                        cur_size[15:8] = b;
                        fidx           = '0;
                        if (cur_size > size_limit)
                        begin
                            phase = PH_HUNT;
                            reports_due.push_back(make_report(KIND_OVERSIZE, cur_type, 1, 1, 0,
                                                              '0, 1'b0));
                        end
                        else
                        begin
                            phase = PH_STAMP;
                        end
                    end
                end
                PH_STAMP:
                begin
                    if (fidx == '0)
                        cur_stamp = {24'h0, b};
                    else
                        cur_stamp[8*fidx +: 8] = b;
                    if (fidx != FIDX_LAST_STAMP)
                    begin
                        fidx = fidx + 2'd1;
                    end
                    else
                    begin
                        fidx = '0;
                        if (cur_size == '0)
                        begin
                            phase = PH_HUNT;
                            reports_due.push_back(make_report(KIND_HEADER, cur_type, 1, 1, 1,
                                                              '0, 1'b1));
                        end
                        else
                        begin
                            phase     = PH_PAYLOAD;
                            remaining = cur_size;
                            reports_due.push_back(make_report(KIND_HEADER, cur_type, 1, 1, 1,
                                                              '0, 1'b0));
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    last = (remaining <= 16'd1);
                    if (last)
                    begin
                        remaining = '0;
                        phase     = PH_HUNT;
                    end
                    else
                    begin
                        remaining = remaining - 16'd1;
                    end
                    reports_due.push_back(make_report(KIND_PAYLOAD, cur_type, 1, 1, 1, b, last));
                end
                default:
                begin
                    if (b == start_code)
                    begin
                        phase = PH_TYPE;
                        fidx  = '0;
                    end
                    else
                    begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        endfunction

        function void compare_report(frame_report_t got);
            frame_report_t want;
            logic [31:0]   w[8];
            logic [31:0]   g[8];
            string         names[8];
            if (reports_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("Unexpected report: kind %0d, type %02h", got.kind, got.ftype);
                return;
            end
            want = reports_due.pop_front();
            kind_count[want.kind]++;
            names = '{"result_kind", "frame_type", "beacon", "sensor", "payload_size",
                      "stamp", "payload_byte", "frame_end"};
            w = '{want.kind, want.ftype, want.beacon_val, want.sensor_val, want.size,
                  want.ts, want.pbyte, want.last};
            g = '{got.kind, got.ftype, got.beacon_val, got.sensor_val, got.size,
                  got.ts, got.pbyte, got.last};
            foreach (w[i])
            begin
                if (w[i] !== g[i])
                begin
                    faults++;
                    if (faults <= 10)
                        $display("Mismatch on %s: expected %0h, got %0h", names[i], w[i], g[i]);
                end
            end
        endfunction
    endclass

endpackage

[tb/sv/tb_sensor_frame_deframer.sv]
// Top-level testbench of the sensor frame deframer with stimulus, stalls and checking.
module tb_sensor_frame_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;
    import sfd_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef enum {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_style_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_write;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;
    logic      in_valid;
    logic      in_stall;
    byte_t     rx_byte;
    logic      out_valid;
    logic      out_stall;
    kind_t     result_kind;
    byte_t     frame_type;
    byte_t     beacon;
    byte_t     sensor;
    size_t     payload_size;
    stamp_t    stamp;
    byte_t     payload_byte;
    logic      frame_end;

    frame_report_tracker tracker = new();

    int unsigned  cycles = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  burst_left = 0;
    stall_style_t stall_style = STALL_NONE;
    int unsigned  stall_phase_left = 0;
    int unsigned  stall_run = 0;
    logic         stall_hold = 1'b0;

    sensor_frame_deframer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .frame_type   (frame_type),
        .beacon       (beacon),
        .sensor       (sensor),
        .payload_size (payload_size),
        .stamp        (stamp),
        .payload_byte (payload_byte),
        .frame_end    (frame_end)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d reports outstanding",
                     tracker.reports_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.accept_byte(rx_byte);
            if (out_valid && !out_stall)
                tracker.compare_report(frame_report_t'{result_kind, frame_type, beacon, sensor,
                                                       payload_size, stamp, payload_byte,
                                                       frame_end});
        end
    end

    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_style      = stall_style_t'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(64, 256);
        end
        stall_phase_left--;
        case (stall_style)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_hold = !stall_hold;
                    stall_run  = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                stall_run--;
                out_stall <= stall_hold;
            end
        endcase
    end

    task automatic send_byte(input byte_t b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic send_frame(input byte_t ftype, input byte_t beacon_val,
                              input byte_t sensor_val, input size_t size, input stamp_t ts);
        send_byte(tracker.start_code);
        send_byte(ftype);
        if (ftype != tracker.raw_code && ftype != tracker.comp_code)
            return;
        send_byte(beacon_val);
        send_byte(sensor_val);
        send_byte(size[7:0]);
        send_byte(size[15:8]);
        if (size > tracker.size_limit)
            return;
        for (int i = 0; i < 4; i++)
            send_byte(ts[8*i +: 8]);
        for (int i = 0; i < size; i++)
            send_byte(($urandom_range(0, 5) == 0) ? tracker.start_code : byte_t'($urandom()));
    endtask

    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_register(input cfg_idx_t idx, input cfg_data_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_register(idx, data);
        @(posedge clk);
    endtask

    task automatic set_registers(input byte_t sc, input byte_t raw, input byte_t comp,
                                 input size_t limit);
        put_register(REG_START_CODE, {8'h00, sc});
        put_register(REG_RAW_TYPE, {8'h00, raw});
        put_register(REG_COMPRESSED_TYPE, {8'h00, comp});
        put_register(REG_SIZE_LIMIT, limit);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input int unsigned budget);
        int unsigned first;
        int unsigned noise;
        int unsigned pick;
        byte_t       t;
        byte_t       good;
        size_t       cap;
        first = bytes_sent;
        noise = 0;
        while (bytes_sent - first - noise < budget)
        begin
            pick = $urandom_range(0, 99);
            good = $urandom_range(0, 1) ? tracker.raw_code : tracker.comp_code;
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(byte_t'($urandom()));
                    noise++;
                end
            end
            else if (pick < 18)
            begin
                do t = byte_t'($urandom()); while (t == tracker.raw_code || t == tracker.comp_code);
                send_frame(t, byte_t'($urandom()), byte_t'($urandom()), '0, '0);
            end
            else if (pick < 28 && tracker.size_limit != 16'hFFFF)
            begin
                send_frame(good, byte_t'($urandom()), byte_t'($urandom()),
                           size_t'($urandom_range(tracker.size_limit + 1, 16'hFFFF)), '0);
            end
            else
            begin
                if (pick < 95)
                    cap = (tracker.size_limit < 16'd10) ? tracker.size_limit : 16'd10;
                else
                    cap = (tracker.size_limit < 16'd160) ? tracker.size_limit : 16'd160;
                send_frame(good, byte_t'($urandom()), byte_t'($urandom()),
                           size_t'($urandom_range(0, cap)), stamp_t'($urandom()));
            end
        end
    endtask

    initial
    begin
        byte_t  sc;
        byte_t  code;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_START_CODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(RST_RAW_TYPE, 8'h00, 8'hFF, 16'd0, 32'hFFFF_FFFF);
        send_frame(8'h00, 8'h00, 8'h00, 16'd0, 32'h0);
        send_frame(8'hFF, 8'h00, 8'h00, 16'd0, 32'h0);
        send_frame(RST_COMPRESSED_TYPE, 8'hFF, 8'h00, RST_SIZE_LIMIT + 16'd1, 32'h0);
        drain();

        set_registers(8'h00, 8'hFF, 8'h00, 16'hFFFF);
        send_frame(8'hFF, 8'h5A, 8'hA5, 16'd2, {4{8'h00}});
        send_frame(8'h7F, 8'h00, 8'h00, 16'd0, 32'h0);
        run_traffic(350);
        drain();

        set_registers(8'hFF, 8'h00, 8'hFF, 16'd0);
        run_traffic(300);
        drain();

        set_registers(byte_t'($urandom()), byte_t'($urandom()), byte_t'($urandom()),
                      size_t'($urandom_range(0, 300)));
        run_traffic(450);
        drain();

        sc   = byte_t'($urandom());
        code = byte_t'($urandom());
        set_registers(sc, code, code, 16'd16);
        run_traffic(400);
        drain();

        set_registers(RST_START_CODE, RST_RAW_TYPE, RST_COMPRESSED_TYPE, RST_SIZE_LIMIT);
        run_traffic(450);
        drain();

        $display("Drove %0d bytes through six register settings, extremes included.",
                 bytes_sent);
        $display("Checked %0d headers, %0d payload bytes, %0d bad types and %0d oversize frames.",
                 tracker.kind_count[KIND_HEADER], tracker.kind_count[KIND_PAYLOAD],
                 tracker.kind_count[KIND_BAD_TYPE], tracker.kind_count[KIND_OVERSIZE]);
        if (tracker.faults == 0 && tracker.reports_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d faults, %0d reports never seen", tracker.faults,
                     tracker.reports_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
